// ----- rtl/plte_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plte_pkg
// Shared types and constants of the piecewise-linear table evaluator.
// ----------------------------------------------------------------------------
package plte_pkg;

    localparam int MaxPoints = 256;
    localparam int IdxW      = $clog2(MaxPoints);
    localparam int CntW      = IdxW + 1;
    localparam int DataW     = 32;
    localparam int DivSteps  = 32;
    localparam int DivCntW   = $clog2(DivSteps + 1);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_EVAL   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_RANGE = 3'd1;
    localparam logic [2:0] ST_FEW   = 3'd2;
    localparam logic [2:0] ST_ORDER = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;

    typedef struct packed {
        op_t                     op;
        logic signed [DataW-1:0] point_arg;
        logic signed [DataW-1:0] point_value;
        logic signed [DataW-1:0] query_arg;
    } item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH0,
        S_TEST0,
        S_FWD_RD,
        S_FWD_TEST,
        S_BWD_RD,
        S_BWD_TEST,
        S_LD0,
        S_LD1,
        S_LD2,
        S_SPAN,
        S_DIV,
        S_MUL,
        S_ADD
    } state_t;

endpackage

// ----- rtl/plte_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plte_in_if
// Command channel: op code with breakpoint and query payload.
// ----------------------------------------------------------------------------
interface plte_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] point_arg;
    logic signed [31:0] point_value;
    logic signed [31:0] query_arg;

    modport source (output valid, output op, output point_arg, output point_value,
                    output query_arg, input ready);
    modport sink (input valid, input op, input point_arg, input point_value,
                  input query_arg, output ready);
endinterface

// ----- rtl/plte_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plte_out_if
// Result channel: interpolated value and status.
// ----------------------------------------------------------------------------
interface plte_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic [2:0]         status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink (input valid, input result_value, input status, output ready);
endinterface

// ----- rtl/plte_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plte_front
// Accepts command beats, decodes the op and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module plte_front
(
    input  logic             clk,
    input  logic             rst_n,
    plte_in_if.sink          in_ch,
    output logic             q_valid,
    output plte_pkg::item_t  q_item,
    input  logic             q_pop
);
    import plte_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;
    item_t      item_in;

    assign in_ch.ready = (fill_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign pop         = q_pop && q_valid;
    assign q_valid     = (fill_reg != 2'd0);
    assign q_item      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        item_in.op          = op_t'(in_ch.op);
        item_in.point_arg   = in_ch.point_arg;
        item_in.point_value = in_ch.point_value;
        item_in.query_arg   = in_ch.query_arg;
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ----- rtl/plte_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plte_div
// Restoring divider: floor(num * 2^32 / den) for num < den, one bit a cycle.
// ----------------------------------------------------------------------------
module plte_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [31:0] quot
);
    import plte_pkg::*;

    logic [31:0]        rem_reg;
    logic [31:0]        quot_reg;
    logic [31:0]        den_reg;
    logic [DivCntW-1:0] cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [32:0]        rem2;
    logic               ge;

    assign rem2 = {rem_reg, 1'b0};
    assign ge   = (rem2 >= {1'b0, den_reg});
    assign done = done_reg;
    assign quot = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DivCntW'(DivSteps);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DivCntW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? 32'(rem2 - {1'b0, den_reg}) : rem2[31:0];
            quot_reg <= {quot_reg[30:0], ge};
        end
    end

endmodule

// ----- rtl/plte_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plte_back
// Breakpoint store, interval search, interpolation and result register.
// ----------------------------------------------------------------------------
module plte_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  plte_pkg::item_t  q_item,
    output logic             q_pop,
    plte_out_if.source       out_ch
);
    import plte_pkg::*;

    logic signed [DataW-1:0] arg_mem [MaxPoints];
    logic signed [DataW-1:0] val_mem [MaxPoints];
    logic signed [DataW-1:0] arg_q;
    logic signed [DataW-1:0] val_q;

    state_t                  state_reg;
    state_t                  state_next;
    logic [CntW-1:0]         count_reg;
    logic [IdxW-1:0]         cache_reg;
    logic [IdxW-1:0]         j_reg;
    logic [IdxW-1:0]         last_reg;
    logic signed [DataW-1:0] first_arg_reg;
    logic signed [DataW-1:0] last_arg_reg;
    logic signed [DataW-1:0] a_reg;
    logic signed [DataW-1:0] x0_reg;
    logic signed [DataW-1:0] x1_reg;
    logic signed [DataW-1:0] v0_reg;
    logic signed [DataW-1:0] v1_reg;
    logic [63:0]             prod_reg;
    logic                    neg_reg;
    logic                    out_valid_reg;
    logic signed [DataW-1:0] out_value_reg;
    logic [2:0]              out_status_reg;

    logic                    out_free;
    logic                    take;
    logic [IdxW-1:0]         rd_addr;
    logic                    div_start;
    logic                    div_done;
    logic [31:0]             div_quot;
    logic                    eval_go;
    logic [IdxW-1:0]         last_new;
    logic [IdxW-1:0]         j_start;
    logic [CntW-1:0]         count_inc;
    logic [32:0]             span_w;
    logic [32:0]             d_w;
    logic [31:0]             span;
    logic [31:0]             offset;
    logic signed [32:0]      dv;
    logic [32:0]             dv_mag;
    logic                    fwd_more;
    logic [IdxW:0]           j_inc;
    logic [64:0]             prod_up;
    logic [32:0]             sum_w;

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign take      = (state_reg == S_IDLE) && q_valid && out_free;
    assign q_pop     = take;
    assign last_new  = IdxW'(count_reg - CntW'(2));
    assign j_start   = (cache_reg > last_new) ? last_new : cache_reg;
    assign count_inc = count_reg + 1'b1;
    assign eval_go   = (q_item.op == OP_EVAL) && (count_reg >= CntW'(2))
                       && (q_item.query_arg >= first_arg_reg)
                       && (q_item.query_arg <= last_arg_reg);
    assign span_w    = {x1_reg[31], x1_reg} - {x0_reg[31], x0_reg};
    assign d_w       = {a_reg[31], a_reg} - {x0_reg[31], x0_reg};
    assign span      = span_w[31:0];
    assign offset    = d_w[31:0];
    assign dv        = {v1_reg[31], v1_reg} - {v0_reg[31], v0_reg};
    assign dv_mag    = dv[32] ? 33'(-dv) : 33'(dv);
    assign j_inc     = {1'b0, j_reg} + 1'b1;
    assign fwd_more  = (j_inc < {1'b0, last_reg});
    assign prod_up   = {1'b0, prod_reg} + 65'h0_FFFF_FFFF;
    assign sum_w     = neg_reg ? ({v0_reg[31], v0_reg} - {1'b0, prod_up[63:32]})
                               : ({v0_reg[31], v0_reg} + {1'b0, prod_reg[63:32]});

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_value = out_value_reg;
    assign out_ch.status       = out_status_reg;

    plte_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (offset),
        .den   (span),
        .done  (div_done),
        .quot  (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take && eval_go)
                begin
                    state_next = S_FETCH0;
                end
            end
            S_FETCH0:
            begin
                state_next = S_TEST0;
            end
            S_TEST0:
            begin
                if (a_reg >= arg_q)
                begin
                    state_next = (j_reg < last_reg) ? S_FWD_RD : S_LD0;
                end
                else
                begin
                    state_next = (j_reg != '0) ? S_BWD_RD : S_LD0;
                end
            end
            S_FWD_RD:
            begin
                state_next = S_FWD_TEST;
            end
            S_FWD_TEST:
            begin
                state_next = (a_reg > arg_q && fwd_more) ? S_FWD_RD : S_LD0;
            end
            S_BWD_RD:
            begin
                state_next = S_BWD_TEST;
            end
            S_BWD_TEST:
            begin
                state_next = (a_reg < arg_q && j_reg != '0) ? S_BWD_RD : S_LD0;
            end
            S_LD0:
            begin
                state_next = S_LD1;
            end
            S_LD1:
            begin
                state_next = S_LD2;
            end
            S_LD2:
            begin
                state_next = S_SPAN;
            end
            S_SPAN:
            begin
                state_next = (offset >= span) ? S_IDLE : S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // read address and divider start
    always_comb
    begin
        rd_addr   = j_reg;
        div_start = 1'b0;
        case (state_reg)
            S_FWD_RD:
            begin
                rd_addr = j_inc[IdxW-1:0];
            end
            S_LD1:
            begin
                rd_addr = j_inc[IdxW-1:0];
            end
            S_SPAN:
            begin
                div_start = (offset < span);
            end
            default:
            begin
                rd_addr = j_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cache_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (take)
            begin
                case (q_item.op)
                    OP_CLEAR:
                    begin
                        count_reg     <= '0;
                        cache_reg     <= '0;
                        out_valid_reg <= 1'b1;
                    end
                    OP_APPEND:
                    begin
                        out_valid_reg <= 1'b1;
                        if (count_reg != CntW'(MaxPoints)
                            && !(count_reg != '0 && q_item.point_arg <= last_arg_reg))
                        begin
                            count_reg <= count_inc;
                            cache_reg <= count_inc[CntW-1:1];
                        end
                    end
                    OP_EVAL:
                    begin
                        out_valid_reg <= !eval_go;
                    end
                    default:
                    begin
                        out_valid_reg <= 1'b1;
                    end
                endcase
            end
            else if (state_reg == S_SPAN && offset >= span)
            begin
                out_valid_reg <= 1'b1;
                cache_reg     <= j_reg;
            end
            else if (state_reg == S_ADD)
            begin
                out_valid_reg <= 1'b1;
                cache_reg     <= j_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        arg_q <= arg_mem[rd_addr];
        val_q <= val_mem[rd_addr];
        if (take && q_item.op == OP_APPEND && count_reg != CntW'(MaxPoints)
            && !(count_reg != '0 && q_item.point_arg <= last_arg_reg))
        begin
            arg_mem[count_reg[IdxW-1:0]] <= q_item.point_arg;
            val_mem[count_reg[IdxW-1:0]] <= q_item.point_value;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_value_reg <= '0;
            case (q_item.op)
                OP_CLEAR:
                begin
                    out_status_reg <= ST_OK;
                end
                OP_APPEND:
                begin
                    if (count_reg == CntW'(MaxPoints))
                    begin
                        out_status_reg <= ST_FULL;
                    end
                    else if (count_reg != '0 && q_item.point_arg <= last_arg_reg)
                    begin
                        out_status_reg <= ST_ORDER;
                    end
                    else
                    begin
                        out_status_reg <= ST_OK;
                        last_arg_reg   <= q_item.point_arg;
                        if (count_reg == '0)
                        begin
                            first_arg_reg <= q_item.point_arg;
                        end
                    end
                end
                OP_EVAL:
                begin
                    out_status_reg <= (count_reg < CntW'(2)) ? ST_FEW :
                                      (eval_go ? ST_OK : ST_RANGE);
                    a_reg    <= q_item.query_arg;
                    last_reg <= last_new;
                    j_reg    <= j_start;
                end
                default:
                begin
                    out_status_reg <= ST_OK;
                end
            endcase
        end
        else
        begin
            case (state_reg)
                S_TEST0:
                begin
                    if (a_reg < arg_q && j_reg != '0)
                    begin
                        j_reg <= j_reg - 1'b1;
                    end
                end
                S_FWD_TEST:
                begin
                    if (a_reg > arg_q)
                    begin
                        j_reg <= j_inc[IdxW-1:0];
                    end
                end
                S_BWD_TEST:
                begin
                    if (a_reg < arg_q && j_reg != '0)
                    begin
                        j_reg <= j_reg - 1'b1;
                    end
                end
                S_LD1:
                begin
                    x0_reg <= arg_q;
                    v0_reg <= val_q;
                end
                S_LD2:
                begin
                    x1_reg <= arg_q;
                    v1_reg <= val_q;
                end
                S_SPAN:
                begin
                    if (offset >= span)
                    begin
                        out_value_reg <= v1_reg;
                    end
                end
                S_MUL:
                begin
                    prod_reg <= dv_mag[31:0] * div_quot;
                    neg_reg  <= dv[32];
                end
                S_ADD:
                begin
                    out_value_reg <= sum_w[31:0];
                end
                default:
                begin
                    out_value_reg <= out_value_reg;
                end
            endcase
        end
    end

endmodule

// ----- rtl/piecewise_linear_table_eval_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_eval_top
// Piecewise-linear table evaluator, signed Q16.16.
//
// Channels: in_ch carries op, point_arg, point_value and query_arg; out_ch
// returns result_value and status, exactly one beat for every input beat, in
// order. Both use valid/ready; a beat moves when both are high.
// A two-entry queue takes input beats while the back end works, so the input
// side stalls only when that queue is full.
// Clear, append and rejected evaluations pass only through the queue and the
// result register. An evaluation that hits passes the queue, reads and tests
// the start breakpoint, walks from the cached interval one breakpoint at a
// time, loads the interval, runs the bit-serial divider for the weight,
// multiplies and adds, and ends in the result register. An argument on the
// right end of its interval skips the divider. One item is evaluated at a time.
// Reset empties the table, the cached interval and the queue; the breakpoint
// memory itself is not cleared. A stalled receiver holds the result register
// and the back end takes no new item until that beat has gone.
// ----------------------------------------------------------------------------
module piecewise_linear_table_eval_top
(
    input  logic clk,
    input  logic rst_n,
    plte_in_if.sink    in_ch,
    plte_out_if.source out_ch
);
    import plte_pkg::*;

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    plte_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    plte_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

// ----- verif/plte_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plte_checker
// Watches the command and result channels of the table evaluator. It keeps
// its own copy of the breakpoint table, works out the result of every
// accepted command beat and compares each result beat, in order, with the
// oldest outstanding one.
// ----------------------------------------------------------------------------
module plte_checker
(
    input  logic clk,
    input  logic rst_n,
    plte_in_if   in_ch,
    plte_out_if  out_ch,
    output int   errors,
    output int   pending
);
    import plte_pkg::*;

    typedef struct {
        logic signed [31:0] value;
        logic [2:0]         status;
    } outcome_t;

    logic signed [31:0] tbl_arg [MaxPoints];
    logic signed [31:0] tbl_val [MaxPoints];
    int unsigned        n_points;
    int unsigned        hit_interval;
    outcome_t           outcomes_due [$];

    function automatic longint lerp(int unsigned j, longint a);
        longint      x0;
        longint      x1;
        longint      v0;
        longint      v1;
        longint      dv;
        bit [63:0]   span;
        bit [63:0]   d;
        bit [63:0]   w;
        bit [63:0]   p;
        x0   = tbl_arg[j];
        x1   = tbl_arg[j+1];
        v0   = tbl_val[j];
        v1   = tbl_val[j+1];
        span = x1 - x0;
        d    = a - x0;
        if (span == 0 || d >= span)
            return v1;
        w  = (d << 32) / span;
        dv = v1 - v0;
        if (dv >= 0)
        begin
            p = 64'(dv) * w;
            return v0 + longint'(p >> 32);
        end
        p = 64'(-dv) * w;
        return v0 - longint'((p + 64'hFFFF_FFFF) >> 32);
    endfunction

    function automatic outcome_t evaluate_cmd(logic [1:0] op, logic signed [31:0] pa,
                                              logic signed [31:0] pv,
                                              logic signed [31:0] qa);
        outcome_t    o;
        int unsigned last;
        int unsigned j;
        longint      a;
        o.value  = '0;
        o.status = ST_OK;
        a        = qa;
        case (op_t'(op))
            OP_CLEAR:
            begin
                n_points     = 0;
                hit_interval = 0;
            end
            OP_APPEND:
            begin
                if (n_points >= MaxPoints)
                    o.status = ST_FULL;
                else if (n_points > 0 && pa <= tbl_arg[n_points-1])
                    o.status = ST_ORDER;
                else
                begin
                    tbl_arg[n_points] = pa;
                    tbl_val[n_points] = pv;
                    n_points++;
                    hit_interval = n_points / 2;
                end
            end
            OP_EVAL:
            begin
                if (n_points < 2)
                    o.status = ST_FEW;
                else if (a < longint'(tbl_arg[0]) || a > longint'(tbl_arg[n_points-1]))
                    o.status = ST_RANGE;
                else
                begin
                    last = n_points - 2;
                    j    = (hit_interval > last) ? last : hit_interval;
                    if (a >= longint'(tbl_arg[j]))
                    begin
                        while (j < last && a > longint'(tbl_arg[j+1]))
                            j++;
                    end
                    else
                    begin
                        while (j > 0 && a < longint'(tbl_arg[j]))
                            j--;
                    end
                    hit_interval = j;
                    o.value      = 32'(lerp(j, a));
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t exp_o;
        if (!rst_n)
        begin
            n_points     = 0;
            hit_interval = 0;
            errors       = 0;
            outcomes_due.delete();
            pending      = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (outcomes_due.size() == 0)
                begin
                    $display("%0t: result beat with nothing due: value %h status %0d",
                             $time, out_ch.result_value, out_ch.status);
                    errors = errors + 1;
                end
                else
                begin
                    exp_o = outcomes_due.pop_front();
                    if (exp_o.value !== out_ch.result_value)
                    begin
                        $display("%0t: result_value expected %h actual %h",
                                 $time, exp_o.value, out_ch.result_value);
                        errors = errors + 1;
                    end
                    if (exp_o.status !== out_ch.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_o.status, out_ch.status);
                        errors = errors + 1;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                outcomes_due.push_back(evaluate_cmd(in_ch.op, in_ch.point_arg,
                                                    in_ch.point_value, in_ch.query_arg));
            pending = outcomes_due.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the table evaluator with a short directed run and then random
// table builds followed by evaluations, under changing idle and stall
// patterns on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
    import plte_pkg::*;

    localparam int CycleLimit  = 1000000;
    localparam int TargetItems = 550;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycles;
    int   sent;
    int   idle_pct;
    int   stall_pct;
    bit   filled;

    plte_in_if  in_ch ();
    plte_out_if out_ch ();

    piecewise_linear_table_eval_top dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    plte_checker chk
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .errors  (errors),
        .pending (pending)
    );

    longint pts [$];

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= stall_pct);

    always_comb
    begin
        case ((sent / 140) % 4)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 79; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 79; end
            default: begin idle_pct = 31; stall_pct = 31; end
        endcase
    end

    task automatic send_cmd(op_t op, longint pa, longint pv, longint qa);
        if ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= op;
        in_ch.point_arg   <= 32'(pa);
        in_ch.point_value <= 32'(pv);
        in_ch.query_arg   <= 32'(qa);
        do
            @(posedge clk);
        while (!in_ch.ready);
        sent++;
    endtask

    function automatic longint rand32();
        return longint'(signed'($urandom()));
    endfunction

    task automatic append_pt(longint pa, longint pv);
        if (pts.size() < MaxPoints && (pts.size() == 0 || pa > pts[$]))
            pts.push_back(pa);
        send_cmd(OP_APPEND, pa, pv, 0);
    endtask

    task automatic build_table();
        int     n;
        longint cur;
        longint step;
        longint lim;
        pts.delete();
        send_cmd(OP_CLEAR, rand32(), rand32(), rand32());
        if (!filled && sent > 150)
        begin
            filled = 1;
            cur = -64'sd2147483648 + $urandom_range(1000);
            for (int i = 0; i < MaxPoints + 3; i++)
            begin
                append_pt(cur, rand32());
                cur += $urandom_range(1, 1 << 23);
            end
            return;
        end
        n = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 12);
        case ($urandom_range(3))
            0:       cur = -64'sd2147483648;
            1:       cur = rand32();
            default: cur = longint'(signed'(16'($urandom())));
        endcase
        for (int i = 0; i < n; i++)
        begin
            if (cur > 64'sd2147483647)
                break;
            if (i > 0 && $urandom_range(9) == 0)
                send_cmd(OP_APPEND, pts[$] - $urandom_range(3), rand32(), rand32());
            append_pt(cur, ($urandom_range(7) == 0) ?
                      (($urandom_range(1) == 0) ? -64'sd2147483648 : 64'sd2147483647) :
                      rand32());
            lim = 64'sd4294967295 / n;
            case ($urandom_range(2))
                0:       step = $urandom_range(1, 16);
                1:       step = $urandom_range(1, 1 << 16);
                default: step = $urandom_range(1, 32'(lim));
            endcase
            cur += step;
        end
    endtask

    task automatic query_table();
        int     m;
        int     j;
        longint span;
        longint qa;
        m = $urandom_range(3, 10);
        for (int k = 0; k < m; k++)
        begin
            if (pts.size() < 2 || $urandom_range(9) == 0)
            begin
                case ($urandom_range(3))
                    0:       qa = -64'sd2147483648;
                    1:       qa = 64'sd2147483647;
                    default: qa = rand32();
                endcase
                send_cmd(($urandom_range(5) == 0) ? OP_NONE : OP_EVAL, rand32(), rand32(), qa);
            end
            else
            begin
                j    = $urandom_range(pts.size() - 2);
                span = pts[j+1] - pts[j];
                case ($urandom_range(5))
                    0:       qa = pts[j];
                    1:       qa = pts[j+1];
                    2:       qa = pts[0] - 1;
                    3:       qa = pts[$] + 1;
                    default: qa = pts[j] + ($urandom() % (span + 1));
                endcase
                if (qa >= -64'sd2147483648 && qa <= 64'sd2147483647)
                    send_cmd(OP_EVAL, rand32(), rand32(), qa);
            end
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cycles            = 0;
        sent              = 0;
        filled            = 0;
        in_ch.valid       = 1'b0;
        in_ch.op          = OP_CLEAR;
        in_ch.point_arg   = '0;
        in_ch.point_value = '0;
        in_ch.query_arg   = '0;
        out_ch.ready      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, one point, order rejects, extremes
        send_cmd(OP_EVAL, 0, 0, 0);
        send_cmd(OP_NONE, -1, -1, -1);
        send_cmd(OP_APPEND, -64'sd2147483648, 64'sd2147483647, 0);
        send_cmd(OP_EVAL, 0, 0, -64'sd2147483648);
        send_cmd(OP_APPEND, -64'sd2147483648, 0, 0);
        send_cmd(OP_APPEND, 64'sd2147483647, -64'sd2147483648, 0);
        send_cmd(OP_EVAL, 0, 0, -64'sd2147483648);
        send_cmd(OP_EVAL, 0, 0, 64'sd2147483647);
        send_cmd(OP_EVAL, 0, 0, 0);
        send_cmd(OP_EVAL, 0, 0, -1);
        send_cmd(OP_APPEND, 0, 5, 0);
        send_cmd(OP_CLEAR, 0, 0, 0);
        send_cmd(OP_EVAL, 0, 0, 0);
        send_cmd(OP_APPEND, 0, 0, 0);
        send_cmd(OP_APPEND, 65536, 65536 * 3, 0);
        send_cmd(OP_APPEND, 131072, -65536, 0);
        send_cmd(OP_APPEND, 131073, 64'sd2147483647, 0);
        send_cmd(OP_EVAL, 0, 0, -1);
        send_cmd(OP_EVAL, 0, 0, 131074);
        send_cmd(OP_EVAL, 0, 0, 131073);
        send_cmd(OP_EVAL, 0, 0, 1);
        send_cmd(OP_EVAL, 0, 0, 98304);
        send_cmd(OP_EVAL, 0, 0, 65536);
        send_cmd(OP_EVAL, 0, 0, 12345);

        while (sent < TargetItems)
        begin
            build_table();
            query_table();
        end
        in_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- piecewise_linear_table_eval_top.f -----
rtl/plte_pkg.sv
rtl/plte_in_if.sv
rtl/plte_out_if.sv
rtl/plte_front.sv
rtl/plte_div.sv
rtl/plte_back.sv
rtl/piecewise_linear_table_eval_top.sv
verif/plte_checker.sv
verif/tb.sv
